>>> design/search_budget_timer_defines.svh
// Assertion helpers shared by the search budget timer modules.
// Both expect the module to have aclk and aresetn in scope.
`ifndef SEARCH_BUDGET_TIMER_DEFINES_SVH
`define SEARCH_BUDGET_TIMER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SBT_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define SBT_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/sbt_pkg.sv
package sbt_pkg;

    // Deadline check spacing for interrupt queries
    localparam int CHECK_INTERVAL = 32;
    localparam int CD_W           = $clog2(CHECK_INTERVAL + 1);

    // Field and register widths
    localparam int MODE_W    = 3;
    localparam int OVH_W     = 14;
    localparam int TIME_W    = 32;
    localparam int MTG_W     = 8;
    localparam int HMC_W     = 10;
    localparam int LIM_W     = 64;
    localparam int CMD_W     = 3;
    localparam int NODE_W    = 64;
    localparam int DEPTH_W   = 8;
    localparam int BUD_W     = 33;
    localparam int DL_W      = 34;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;

    // Move horizon: min(max(MOVES_MIN, MOVES_BASE - hmc/2), movestogo)
    localparam int MOVES_BASE = 40;
    localparam int MOVES_MIN  = 10;
    localparam int MV_W       = $clog2(MOVES_BASE + 1);

    // Hard limit scaling: left*8/10 and target*4/3
    localparam int MAXT_NUM = 8;
    localparam int MAXT_DEN = 10;
    localparam int SCL_NUM  = 4;
    localparam int SCL_DEN  = 3;

    // Reciprocals for the constant divisions, exact for any 32-bit x:
    // x/5 = (x*RCP5) >> RCP5_SH, x/3 = (x*RCP3) >> RCP3_SH
    localparam logic [TIME_W-1:0] RCP5    = 32'hCCCC_CCCD;
    localparam int                RCP5_SH = 34;
    localparam logic [TIME_W-1:0] RCP3    = 32'hAAAA_AAAB;
    localparam int                RCP3_SH = 33;

    // Time share divider: dividend up to (2^32-1)*40, divisor up to 40
    localparam int DVD_W  = 38;
    localparam int DVS_W  = 6;
    localparam int DCNT_W = $clog2(DVD_W);

    // Modes
    localparam logic [MODE_W-1:0] MODE_TC    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INF   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FT    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEPTH = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NODES = 3'd4;

    // Commands
    localparam logic [CMD_W-1:0] CMD_START = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PLY   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PROBE = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OVH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INC   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MTG   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HMC   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 3'd6;

    // Controller to datapath
    typedef struct packed {
        logic ld_item;
        logic plan_moves;
        logic plan_num;
        logic div_start;
        logic div_cap;
        logic scale_mul;
        logic scale_sum;
        logic commit;
    } sbt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic plan_req;
        logic div_busy;
        logic out_free;
    } sbt_sts_t;

endpackage

>>> design/sbt_div.sv
// Restoring divider, one quotient bit per cycle
module sbt_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [sbt_pkg::DVD_W-1:0] dividend,
    input  logic [sbt_pkg::DVS_W-1:0] divisor,
    output logic                      busy,
    output logic [sbt_pkg::DVD_W-1:0] quotient
);

    logic [sbt_pkg::DVD_W-1:0]  quo_reg, quo_next;
    logic [sbt_pkg::DVS_W-1:0]  rem_reg, rem_next;
    logic [sbt_pkg::DVS_W-1:0]  dvs_reg, dvs_next;
    logic [sbt_pkg::DCNT_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic [sbt_pkg::DVS_W:0]    trial;
    logic [sbt_pkg::DVS_W:0]    diff;
    logic                       fits;

    // shift in next dividend bit, try subtract
    always_comb begin
        trial     = {rem_reg, quo_reg[sbt_pkg::DVD_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        fits      = (trial >= {1'b0, dvs_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[sbt_pkg::DVS_W-1:0] : trial[sbt_pkg::DVS_W-1:0];
            quo_next = {quo_reg[sbt_pkg::DVD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == sbt_pkg::DCNT_W'(sbt_pkg::DVD_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

>>> design/sbt_ctrl.sv
`include "search_budget_timer_defines.svh"

// Sequencer: accept, optional budget planning, commit into output stage
module sbt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sbt_pkg::sbt_sts_t sts,
    output sbt_pkg::sbt_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_PL_MOV = 3'd2;
    localparam logic [2:0] ST_PL_NUM = 3'd3;
    localparam logic [2:0] ST_DV_GO  = 3'd4;
    localparam logic [2:0] ST_DV_RUN = 3'd5;
    localparam logic [2:0] ST_SC_MUL = 3'd6;
    localparam logic [2:0] ST_SC_SUM = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       take;

    // no word taken while in reset
    assign s_ready = (state_reg == ST_IDLE) && aresetn;
    assign take    = s_valid && s_ready;

    // next state and command decode
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.ld_item = take;
        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    state_next = sts.plan_req ? ST_PL_MOV : ST_EXEC;
                end
            end
            ST_PL_MOV: begin
                cmd.plan_moves = 1'b1;
                state_next     = ST_PL_NUM;
            end
            ST_PL_NUM: begin
                cmd.plan_num = 1'b1;
                state_next   = ST_DV_GO;
            end
            ST_DV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DV_RUN;
            end
            ST_DV_RUN: begin
                if (!sts.div_busy) begin
                    cmd.div_cap = 1'b1;
                    state_next  = ST_SC_MUL;
                end
            end
            ST_SC_MUL: begin
                cmd.scale_mul = 1'b1;
                state_next    = ST_SC_SUM;
            end
            ST_SC_SUM: begin
                cmd.scale_sum = 1'b1;
                state_next    = ST_EXEC;
            end
            ST_EXEC: begin
                // wait for room in the output stage
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `SBT_CHECK(ctrl_commit_has_room, cmd.commit, sts.out_free, "commit into a full output stage")
    `SBT_CHECK(ctrl_div_start_free, cmd.div_start, !sts.div_busy, "divider restarted while busy")
    `SBT_CHECK_NEXT(ctrl_div_runs, cmd.div_start, sts.div_busy, "divider did not pick up job")

endmodule

>>> design/sbt_dp.sv
`include "search_budget_timer_defines.svh"

// Registers, budget arithmetic, stop decisions and the output stage
module sbt_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  sbt_pkg::sbt_cmd_t                 cmd,
    output sbt_pkg::sbt_sts_t                 sts,
    input  logic                              cfg_wr_en,
    input  logic [sbt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sbt_pkg::CFG_DAT_W-1:0]     cfg_wdata,
    input  logic [sbt_pkg::CMD_W-1:0]         s_cmd,
    input  logic [sbt_pkg::NODE_W-1:0]        s_nodes_searched,
    input  logic [sbt_pkg::DEPTH_W-1:0]       s_depth_done,
    input  logic                              m_ready,
    output logic                              m_valid,
    output logic                              m_stop,
    output logic signed [sbt_pkg::BUD_W-1:0]  m_soft_budget_ms,
    output logic signed [sbt_pkg::BUD_W-1:0]  m_hard_budget_ms,
    output logic [sbt_pkg::TIME_W-1:0]        m_elapsed_ms
);

    // configuration
    logic [sbt_pkg::MODE_W-1:0] mode_reg;
    logic [sbt_pkg::OVH_W-1:0]  ovh_reg;
    logic [sbt_pkg::TIME_W-1:0] left_reg;
    logic [sbt_pkg::TIME_W-1:0] inc_reg;
    logic [sbt_pkg::MTG_W-1:0]  mtg_reg;
    logic [sbt_pkg::HMC_W-1:0]  hmc_reg;
    logic [sbt_pkg::LIM_W-1:0]  limit_reg;

    // latched input word
    logic [sbt_pkg::CMD_W-1:0]   icmd_reg;
    logic [sbt_pkg::NODE_W-1:0]  nodes_reg;
    logic [sbt_pkg::DEPTH_W-1:0] depth_reg;

    // search state
    logic [sbt_pkg::TIME_W-1:0]      elapsed_reg, elapsed_next;
    logic signed [sbt_pkg::DL_W-1:0] soft_reg, soft_next;
    logic signed [sbt_pkg::DL_W-1:0] hard_reg, hard_next;
    logic [sbt_pkg::CD_W-1:0]        cd_reg, cd_next;
    logic                            stop_next;

    // planning
    logic [sbt_pkg::HMC_W-2:0]       half_hmc;
    logic [sbt_pkg::MV_W-1:0]        base_moves;
    logic [sbt_pkg::MTG_W-1:0]       mtg_eff;
    logic [sbt_pkg::MV_W-1:0]        moves_calc, moves_reg;
    logic [sbt_pkg::DVD_W-1:0]       prod;
    logic [sbt_pkg::DVD_W-1:0]       num_reg;
    logic [2*sbt_pkg::TIME_W-1:0]    fifth_prod, third_prod;
    logic [sbt_pkg::TIME_W-3:0]      fifth_reg;
    logic [2:0]                      fifth_rem, fifth_frac;
    logic [sbt_pkg::TIME_W-2:0]      third_reg;
    logic signed [sbt_pkg::DL_W-1:0] tgt_reg, maxt_reg, scl_reg;
    logic [sbt_pkg::TIME_W-1:0]      tgt_abs;
    logic [sbt_pkg::DL_W-1:0]        scl_mag;
    logic signed [sbt_pkg::DL_W-1:0] quo_s, ovh_s;
    logic signed [sbt_pkg::DL_W-1:0] hard_plan, soft_sum, soft_plan;
    logic [sbt_pkg::TIME_W-1:0]      lim_sat;
    logic signed [sbt_pkg::DL_W-1:0] fix_dl;

    // divider hookup
    logic                      div_busy;
    logic [sbt_pkg::DVD_W-1:0] div_quo;

    // output stage
    logic                            m_valid_reg, m_valid_next;
    logic                            stop_out_reg;
    logic signed [sbt_pkg::BUD_W-1:0] soft_out_reg, hard_out_reg;
    logic [sbt_pkg::TIME_W-1:0]      elapsed_out_reg;

    logic                            timed;
    logic signed [sbt_pkg::DL_W-1:0] elap_s;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= sbt_pkg::MODE_INF;
            ovh_reg   <= sbt_pkg::OVH_W'(100);
            left_reg  <= '0;
            inc_reg   <= '0;
            mtg_reg   <= sbt_pkg::MTG_W'(sbt_pkg::MOVES_BASE);
            hmc_reg   <= '0;
            limit_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                sbt_pkg::REG_MODE:  mode_reg  <= cfg_wdata[sbt_pkg::MODE_W-1:0];
                sbt_pkg::REG_OVH:   ovh_reg   <= cfg_wdata[sbt_pkg::OVH_W-1:0];
                sbt_pkg::REG_LEFT:  left_reg  <= cfg_wdata[sbt_pkg::TIME_W-1:0];
                sbt_pkg::REG_INC:   inc_reg   <= cfg_wdata[sbt_pkg::TIME_W-1:0];
                sbt_pkg::REG_MTG:   mtg_reg   <= cfg_wdata[sbt_pkg::MTG_W-1:0];
                sbt_pkg::REG_HMC:   hmc_reg   <= cfg_wdata[sbt_pkg::HMC_W-1:0];
                sbt_pkg::REG_LIMIT: limit_reg <= cfg_wdata[sbt_pkg::LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input word latch
    always_ff @(posedge aclk) begin
        if (cmd.ld_item) begin
            icmd_reg  <= s_cmd;
            nodes_reg <= s_nodes_searched;
            depth_reg <= s_depth_done;
        end
    end

    // move horizon
    always_comb begin
        half_hmc = hmc_reg[sbt_pkg::HMC_W-1:1];
        if (half_hmc >= (sbt_pkg::HMC_W-1)'(sbt_pkg::MOVES_BASE - sbt_pkg::MOVES_MIN)) begin
            base_moves = sbt_pkg::MV_W'(sbt_pkg::MOVES_MIN);
        end else begin
            base_moves = sbt_pkg::MV_W'((sbt_pkg::HMC_W-1)'(sbt_pkg::MOVES_BASE) - half_hmc);
        end
        mtg_eff = (mtg_reg == '0) ? sbt_pkg::MTG_W'(1) : mtg_reg;
        if (mtg_eff < sbt_pkg::MTG_W'(base_moves)) begin
            moves_calc = mtg_eff[sbt_pkg::MV_W-1:0];
        end else begin
            moves_calc = base_moves;
        end
    end

    // left + inc*(moves-1), 32x6 product
    assign prod = sbt_pkg::DVD_W'(inc_reg) * sbt_pkg::DVD_W'(moves_reg - 1'b1);

    // left*8/10 = 4*(left/5) + floor(4*(left mod 5)/5); the last term is rem-1 for rem > 0
    assign fifth_prod = (2*sbt_pkg::TIME_W)'(left_reg) * (2*sbt_pkg::TIME_W)'(sbt_pkg::RCP5);
    assign fifth_rem  = left_reg[2:0] - (fifth_reg[2:0] * 3'd5);
    assign fifth_frac = (fifth_rem == 3'd0) ? 3'd0 : fifth_rem - 3'd1;

    always_ff @(posedge aclk) begin
        if (cmd.plan_moves) begin
            moves_reg <= moves_calc;
            fifth_reg <= fifth_prod[sbt_pkg::RCP5_SH +: (sbt_pkg::TIME_W-2)];
        end
        if (cmd.plan_num) begin
            num_reg  <= sbt_pkg::DVD_W'(left_reg) + prod;
            maxt_reg <= $signed(sbt_pkg::DL_W'({fifth_reg, 2'b00}))
                        + $signed(sbt_pkg::DL_W'(fifth_frac)) - ovh_s;
        end
    end

    // time share per move: num / moves
    sbt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (num_reg),
        .divisor  (moves_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    assign quo_s = $signed({1'b0, div_quo[sbt_pkg::DL_W-2:0]});
    assign ovh_s = $signed(sbt_pkg::DL_W'(ovh_reg));

    // target*4/3 on the magnitude, |t| + |t|/3, sign put back after
    assign tgt_abs    = tgt_reg[sbt_pkg::DL_W-1] ? sbt_pkg::TIME_W'(-tgt_reg)
                                                 : sbt_pkg::TIME_W'(tgt_reg);
    assign third_prod = (2*sbt_pkg::TIME_W)'(tgt_abs) * (2*sbt_pkg::TIME_W)'(sbt_pkg::RCP3);
    assign scl_mag    = sbt_pkg::DL_W'(tgt_abs) + sbt_pkg::DL_W'(third_reg);

    always_ff @(posedge aclk) begin
        if (cmd.div_cap) begin
            tgt_reg <= quo_s - ovh_s;
        end
        if (cmd.scale_mul) begin
            third_reg <= third_prod[sbt_pkg::RCP3_SH +: (sbt_pkg::TIME_W-1)];
        end
        if (cmd.scale_sum) begin
            scl_reg <= tgt_reg[sbt_pkg::DL_W-1] ? -$signed(scl_mag) : $signed(scl_mag);
        end
    end

    // hard = min(max time, scaled), soft = hard/2 rounded toward zero
    assign hard_plan = (maxt_reg < scl_reg) ? maxt_reg : scl_reg;
    assign soft_sum  = hard_plan + $signed(sbt_pkg::DL_W'(hard_plan[sbt_pkg::DL_W-1]));
    assign soft_plan = soft_sum >>> 1;

    // fixed-time deadline, limit saturated to 32 bits
    assign lim_sat = (|limit_reg[sbt_pkg::LIM_W-1:sbt_pkg::TIME_W]) ? '1
                                                                     : limit_reg[sbt_pkg::TIME_W-1:0];
    assign fix_dl  = $signed({2'b00, lim_sat}) - ovh_s;

    // word execution
    assign timed  = (mode_reg == sbt_pkg::MODE_TC) || (mode_reg == sbt_pkg::MODE_FT);
    assign elap_s = $signed({2'b00, elapsed_reg});

    always_comb begin
        elapsed_next = elapsed_reg;
        soft_next    = soft_reg;
        hard_next    = hard_reg;
        cd_next      = cd_reg;
        stop_next    = 1'b0;
        case (icmd_reg)
            sbt_pkg::CMD_START: begin
                elapsed_next = '0;
                if (mode_reg == sbt_pkg::MODE_TC) begin
                    soft_next = soft_plan;
                    hard_next = hard_plan;
                end else if (mode_reg == sbt_pkg::MODE_FT) begin
                    soft_next = fix_dl;
                    hard_next = fix_dl;
                end
            end
            sbt_pkg::CMD_TICK: begin
                if (elapsed_reg != '1) begin
                    elapsed_next = elapsed_reg + 1'b1;
                end
            end
            sbt_pkg::CMD_QUERY: begin
                if (timed) begin
                    // deadline only looked at when the countdown has run out
                    if (cd_reg != '0) begin
                        cd_next = cd_reg - 1'b1;
                    end else begin
                        cd_next   = sbt_pkg::CD_W'(sbt_pkg::CHECK_INTERVAL);
                        stop_next = (elap_s >= hard_reg);
                    end
                end else if (mode_reg == sbt_pkg::MODE_NODES) begin
                    stop_next = (nodes_reg >= limit_reg);
                end
            end
            sbt_pkg::CMD_PLY: begin
                if (timed) begin
                    stop_next = (elap_s >= soft_reg);
                end else if (mode_reg == sbt_pkg::MODE_DEPTH) begin
                    stop_next = (sbt_pkg::LIM_W'(depth_reg) >= limit_reg);
                end
            end
            sbt_pkg::CMD_PROBE: begin
                cd_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_reg <= '0;
            soft_reg    <= '0;
            hard_reg    <= '0;
            cd_reg      <= '0;
        end else if (cmd.commit) begin
            elapsed_reg <= elapsed_next;
            soft_reg    <= soft_next;
            hard_reg    <= hard_next;
            cd_reg      <= cd_next;
        end
    end

    // output stage
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            stop_out_reg    <= stop_next;
            soft_out_reg    <= soft_next[sbt_pkg::BUD_W-1:0];
            hard_out_reg    <= hard_next[sbt_pkg::BUD_W-1:0];
            elapsed_out_reg <= elapsed_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_stop           = stop_out_reg;
    assign m_soft_budget_ms = soft_out_reg;
    assign m_hard_budget_ms = hard_out_reg;
    assign m_elapsed_ms     = elapsed_out_reg;

    // status
    assign sts.plan_req = (s_cmd == sbt_pkg::CMD_START) && (mode_reg == sbt_pkg::MODE_TC);
    assign sts.div_busy = div_busy;
    assign sts.out_free = !m_valid_reg || m_ready;

    `SBT_CHECK(dp_countdown_bound, 1'b1, cd_reg <= sbt_pkg::CD_W'(sbt_pkg::CHECK_INTERVAL), "countdown out of range")
    `SBT_CHECK_NEXT(dp_start_clears, cmd.commit && (icmd_reg == sbt_pkg::CMD_START), (elapsed_reg == '0) && m_valid_reg, "start did not clear elapsed time")

endmodule

>>> design/search_budget_timer.sv
// Search stop controller. Tick, interrupt-query, ply-complete and probe words are latched
// on acceptance and then executed into the result register, and a start word in any mode
// other than time control does the same. A start word in time-control mode is latched, then
// plans the move horizon and the divider dividend, works out the time share per move on a
// one-bit-per-cycle 38-bit divider (launch, quotient steps, capture), forms 4/3 of the
// target by reciprocal multiplication (8/10 of the clock is worked out while planning the
// same way), and then commits. A new word is accepted as soon as the
// previous one has been written into the output register, even while that result waits
// for m_ready; the commit of the next word then waits until the output register frees.
// Configuration writes are applied at once and must only be issued while the block is
// idle. Budgets are reported as 33-bit two's complement values relative to the last
// start; the elapsed count saturates at 2^32-1.
module search_budget_timer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [sbt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sbt_pkg::CFG_DAT_W-1:0]     cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [sbt_pkg::CMD_W-1:0]         s_cmd,
    input  logic [sbt_pkg::NODE_W-1:0]        s_nodes_searched,
    input  logic [sbt_pkg::DEPTH_W-1:0]       s_depth_done,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_stop,
    output logic signed [sbt_pkg::BUD_W-1:0]  m_soft_budget_ms,
    output logic signed [sbt_pkg::BUD_W-1:0]  m_hard_budget_ms,
    output logic [sbt_pkg::TIME_W-1:0]        m_elapsed_ms
);

    sbt_pkg::sbt_cmd_t cmd;
    sbt_pkg::sbt_sts_t sts;

    sbt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sbt_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_cmd            (s_cmd),
        .s_nodes_searched (s_nodes_searched),
        .s_depth_done     (s_depth_done),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_stop           (m_stop),
        .m_soft_budget_ms (m_soft_budget_ms),
        .m_hard_budget_ms (m_hard_budget_ms),
        .m_elapsed_ms     (m_elapsed_ms)
    );

endmodule

>>> sim/search_budget_timer_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port, keeps its own copy of the timer,
// and compares every result word with the oldest predicted one.
module search_budget_timer_checker
    import sbt_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DAT_W-1:0]        cfg_wdata,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [CMD_W-1:0]            s_cmd,
    input  logic [NODE_W-1:0]           s_nodes_searched,
    input  logic [DEPTH_W-1:0]          s_depth_done,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic                        m_stop,
    input  logic signed [BUD_W-1:0]     m_soft_budget_ms,
    input  logic signed [BUD_W-1:0]     m_hard_budget_ms,
    input  logic [TIME_W-1:0]           m_elapsed_ms,
    output int unsigned                 errors,
    output int unsigned                 outstanding
);

    typedef struct packed {
        logic              stop;
        logic [BUD_W-1:0]  soft_ms;
        logic [BUD_W-1:0]  hard;
        logic [TIME_W-1:0] elapsed;
    } budget_word_t;

    // Predicted result words, oldest first
    budget_word_t budget_q[$];

    // Register copies
    logic [MODE_W-1:0] mode;
    logic [OVH_W-1:0]  overhead;
    logic [TIME_W-1:0] clock_left;
    logic [TIME_W-1:0] increment;
    logic [MTG_W-1:0]  moves_to_go;
    logic [HMC_W-1:0]  halfmoves;
    logic [LIM_W-1:0]  limit;

    // Timer state; deadlines kept wide and signed
    logic [TIME_W-1:0] elapsed;
    longint            soft_dl;
    longint            hard_dl;
    int                countdown;

    initial begin
        errors      = 0;
        outstanding = 0;
    end

    task automatic report(input string field, input logic [63:0] got,
                          input logic [63:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $time, field, got, want);
        errors++;
    endtask

    // Signed compare of the counter against a deadline
    function automatic bit past(input longint deadline);
        return longint'({32'd0, elapsed}) >= deadline;
    endfunction

    // Time-control budgets, truncating divisions on signed values
    function automatic void plan_clock();
        longint left, inc, mtg, moves, target, max_t, scaled;
        left  = longint'(clock_left);
        inc   = longint'(increment);
        mtg   = (moves_to_go == '0) ? 64'sd1 : longint'(moves_to_go);
        moves = MOVES_BASE - longint'(halfmoves / 2);
        if (moves < MOVES_MIN)
            moves = MOVES_MIN;
        if (mtg < moves)
            moves = mtg;
        target  = (left + inc * (moves - 1)) / moves - longint'(overhead);
        max_t   = left * MAXT_NUM / MAXT_DEN - longint'(overhead);
        scaled  = target * SCL_NUM / SCL_DEN;
        hard_dl = (max_t < scaled) ? max_t : scaled;
        soft_dl = hard_dl / 2;
    endfunction

    // Fixed time: limit clipped to 32 bits, less the margin
    function automatic void plan_fixed();
        logic [LIM_W-1:0] lim;
        lim     = (limit > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : limit;
        soft_dl = longint'(lim) - longint'(overhead);
        hard_dl = soft_dl;
    endfunction

    // Advance the timer by one input word and give the word it should produce
    function automatic budget_word_t next_budget(input logic [CMD_W-1:0] cmd,
                                                 input logic [NODE_W-1:0] nodes,
                                                 input logic [DEPTH_W-1:0] depth);
        budget_word_t w;
        logic stop;
        stop = 1'b0;
        case (cmd)
            CMD_START: begin
                elapsed = '0;
                if (mode == MODE_TC)
                    plan_clock();
                else if (mode == MODE_FT)
                    plan_fixed();
            end
            CMD_TICK: begin
                if (elapsed != '1)
                    elapsed = elapsed + 1'b1;
            end
            CMD_QUERY: begin
                // timed modes only look at the clock every so many queries
                if (mode == MODE_TC || mode == MODE_FT) begin
                    if (countdown > 0) begin
                        countdown--;
                    end else begin
                        countdown = CHECK_INTERVAL;
                        stop      = past(hard_dl);
                    end
                end else if (mode == MODE_NODES) begin
                    stop = nodes >= limit;
                end
            end
            CMD_PLY: begin
                if (mode == MODE_TC || mode == MODE_FT)
                    stop = past(soft_dl);
                else if (mode == MODE_DEPTH)
                    stop = depth >= limit;
            end
            CMD_PROBE: begin
                countdown = 0;
            end
            default: ;
        endcase
        w.stop    = stop;
        w.soft_ms = soft_dl[BUD_W-1:0];
        w.hard    = hard_dl[BUD_W-1:0];
        w.elapsed = elapsed;
        return w;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DAT_W-1:0] data);
        case (idx)
            REG_MODE:  mode        = data[MODE_W-1:0];
            REG_OVH:   overhead    = data[OVH_W-1:0];
            REG_LEFT:  clock_left  = data[TIME_W-1:0];
            REG_INC:   increment   = data[TIME_W-1:0];
            REG_MTG:   moves_to_go = data[MTG_W-1:0];
            REG_HMC:   halfmoves   = data[HMC_W-1:0];
            REG_LIMIT: limit       = data;
            default: ;
        endcase
    endfunction

    // Results are compared before new words are predicted within one edge
    always @(posedge aclk) begin
        budget_word_t got;
        budget_word_t want;
        if (!aresetn) begin
            mode        = MODE_INF;
            overhead    = OVH_W'(100);
            clock_left  = '0;
            increment   = '0;
            moves_to_go = MTG_W'(MOVES_BASE);
            halfmoves   = '0;
            limit       = '0;
            elapsed     = '0;
            soft_dl     = 0;
            hard_dl     = 0;
            countdown   = 0;
            budget_q.delete();
        end else begin
            if (cfg_wr_en)
                apply_reg(cfg_index, cfg_wdata);
            if (m_valid && m_ready) begin
                got = {m_stop, m_soft_budget_ms, m_hard_budget_ms, m_elapsed_ms};
                if (budget_q.size() == 0) begin
                    report("unexpected result word, elapsed", got.elapsed, '0);
                end else begin
                    want = budget_q.pop_front();
                    if (got.stop != want.stop)
                        report("stop", got.stop, want.stop);
                    if (got.soft_ms != want.soft_ms)
                        report("soft budget", got.soft_ms, want.soft_ms);
                    if (got.hard != want.hard)
                        report("hard budget", got.hard, want.hard);
                    if (got.elapsed != want.elapsed)
                        report("elapsed", got.elapsed, want.elapsed);
                end
            end
            if (s_valid && s_ready)
                budget_q.push_back(next_budget(s_cmd, s_nodes_searched, s_depth_done));
        end
        outstanding <= budget_q.size();
    end

endmodule

>>> sim/search_budget_timer_test.sv
`timescale 1ns / 1ps

module search_budget_timer_test;
    import sbt_pkg::*;

    localparam int ITEM_TARGET = 1900;
    localparam int IDLE_PCT    = 23;
    localparam int DRAIN_WAIT  = 150;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DAT_W-1:0]     cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic [CMD_W-1:0]         s_cmd;
    logic [NODE_W-1:0]        s_nodes_searched;
    logic [DEPTH_W-1:0]       s_depth_done;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_stop;
    logic signed [BUD_W-1:0]  m_soft_budget_ms;
    logic signed [BUD_W-1:0]  m_hard_budget_ms;
    logic [TIME_W-1:0]        m_elapsed_ms;
    int unsigned              errors;
    int unsigned              outstanding;

    bit                       calm;
    int unsigned              sent;

    search_budget_timer dut (.*);

    search_budget_timer_checker budget_check (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Result side back-pressure, switched off in the calm phase
    always @(posedge aclk)
        m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Stop sending and wait until every predicted word has come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic set_regs(input logic [MODE_W-1:0] m, input logic [OVH_W-1:0] o,
                            input logic [TIME_W-1:0] l, input logic [TIME_W-1:0] i,
                            input logic [MTG_W-1:0] g, input logic [HMC_W-1:0] h,
                            input logic [LIM_W-1:0] lim);
        wait_idle();
        write_reg(REG_MODE, m);
        write_reg(REG_OVH, o);
        write_reg(REG_LEFT, l);
        write_reg(REG_INC, i);
        write_reg(REG_MTG, g);
        write_reg(REG_HMC, h);
        write_reg(REG_LIMIT, lim);
        cfg_wr_en <= 1'b0;
    endtask

    // One input word, with a random gap in front of it
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [NODE_W-1:0] nodes,
                             input logic [DEPTH_W-1:0] depth);
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            do
                @(posedge aclk);
            while ($urandom_range(0, 99) < IDLE_PCT);
        end
        s_valid          <= 1'b1;
        s_cmd            <= cmd;
        s_nodes_searched <= nodes;
        s_depth_done     <= depth;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sent++;
    endtask

    // A fresh setting, then a run of searches on it
    task automatic run_phase(input int idx);
        logic [MODE_W-1:0]  modes[5];
        logic [MODE_W-1:0]  m;
        logic [OVH_W-1:0]   o;
        logic [TIME_W-1:0]  l;
        logic [TIME_W-1:0]  i;
        logic [MTG_W-1:0]   g;
        logic [HMC_W-1:0]   h;
        logic [LIM_W-1:0]   lim;
        logic [CMD_W-1:0]   c;
        logic [NODE_W-1:0]  nodes;
        logic [DEPTH_W-1:0] depth;
        int                 n;
        int                 roll;
        modes = '{MODE_TC, MODE_INF, MODE_FT, MODE_DEPTH, MODE_NODES};
        m = ($urandom_range(0, 99) < 8) ? MODE_W'($urandom) : modes[idx % 5];

        roll = $urandom_range(0, 99);
        if (roll < 10)      o = OVH_W'(10000);
        else if (roll < 20) o = OVH_W'($urandom_range(0, 10000));
        else                o = OVH_W'($urandom_range(0, 60));

        // mostly small clocks so that ticks reach the deadlines
        roll = $urandom_range(0, 99);
        if (roll < 70)      l = $urandom_range(0, 2500);
        else if (roll < 85) l = $urandom;
        else if (roll < 92) l = '0;
        else                l = '1;

        roll = $urandom_range(0, 99);
        if (roll < 60)      i = $urandom_range(0, 100);
        else if (roll < 80) i = $urandom;
        else if (roll < 90) i = '0;
        else                i = '1;

        roll = $urandom_range(0, 99);
        if (roll < 15)      g = '0;
        else if (roll < 40) g = MTG_W'($urandom_range(1, 10));
        else                g = MTG_W'($urandom);
        h = HMC_W'($urandom);

        roll = $urandom_range(0, 99);
        case (m)
            MODE_FT: begin
                lim = (roll < 80) ? LIM_W'($urandom_range(0, 150)) : {$urandom, $urandom};
            end
            MODE_DEPTH: begin
                lim = (roll < 80) ? LIM_W'($urandom_range(0, 60)) : {$urandom, $urandom};
            end
            default: begin
                if (roll < 5)       lim = '0;
                else if (roll < 10) lim = '1;
                else                lim = {$urandom, $urandom};
            end
        endcase
        set_regs(m, o, l, i, g, h, lim);

        n = $urandom_range(60, 160);
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            if ((k == 0 && roll < 85) || roll < 2) c = CMD_START;
            else if (roll < 42) c = CMD_TICK;
            else if (roll < 72) c = CMD_QUERY;
            else if (roll < 87) c = CMD_PLY;
            else if (roll < 93) c = CMD_PROBE;
            else if (roll < 95) c = CMD_W'($urandom_range(CMD_PROBE + 1, (1 << CMD_W) - 1));
            else                c = CMD_TICK;

            // node counts and depths close to the targets half the time
            if (m == MODE_NODES && $urandom_range(0, 1))
                nodes = lim + NODE_W'($urandom_range(0, 4)) - NODE_W'(2);
            else
                nodes = {$urandom, $urandom};
            if (m == MODE_DEPTH && $urandom_range(0, 1))
                depth = DEPTH_W'($urandom_range(0, 70));
            else
                depth = DEPTH_W'($urandom);
            send_word(c, nodes, depth);
        end
    endtask

    initial begin
        aresetn          <= 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_index        <= '0;
        cfg_wdata        <= '0;
        s_valid          <= 1'b0;
        s_cmd            <= CMD_START;
        s_nodes_searched <= '0;
        s_depth_done     <= '0;
        calm = 1'b0;
        sent = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Values after reset: infinite mode, every command once
        send_word(CMD_START, '0, '0);
        send_word(CMD_TICK, '1, '1);
        send_word(CMD_QUERY, '1, '0);
        send_word(CMD_PLY, '0, '1);
        send_word(CMD_PROBE, '0, '0);
        for (int u = CMD_PROBE + 1; u < (1 << CMD_W); u++)
            send_word(CMD_W'(u), '1, '1);

        // Time control with clock, increment, half-moves and limit at their top values; no moves to go counts as one
        set_regs(MODE_TC, OVH_W'(10000), '1, '1, '0, '1, '1);
        send_word(CMD_START, '0, '0);

        // Empty clock: deadlines go negative and the first query looks at once
        set_regs(MODE_TC, OVH_W'(10000), '0, '0, '1, '0, '0);
        send_word(CMD_START, '0, '0);
        send_word(CMD_QUERY, '0, '0);
        send_word(CMD_PLY, '0, '0);

        // Fixed time with a limit beyond 32 bits
        set_regs(MODE_FT, '0, '0, '0, MTG_W'(MOVES_BASE), '0, '1);
        send_word(CMD_START, '0, '0);
        send_word(CMD_QUERY, '0, '0);
        send_word(CMD_PLY, '0, '0);

        // Fixed time shorter than the margin
        set_regs(MODE_FT, OVH_W'(100), '0, '0, MTG_W'(MOVES_BASE), '0, LIM_W'(50));
        send_word(CMD_START, '0, '0);

        // Depth targets at both ends
        set_regs(MODE_DEPTH, '0, '0, '0, '0, '0, '1);
        send_word(CMD_PLY, '0, '1);
        set_regs(MODE_DEPTH, '0, '0, '0, '0, '0, '0);
        send_word(CMD_PLY, '0, '0);

        // Node targets at both ends
        set_regs(MODE_NODES, '0, '0, '0, '0, '0, '1);
        send_word(CMD_QUERY, '1, '0);
        send_word(CMD_QUERY, ~NODE_W'(1), '0);
        set_regs(MODE_NODES, '0, '0, '0, '0, '0, '0);
        send_word(CMD_QUERY, '0, '0);

        // Mode code past the last one never stops
        set_regs(MODE_NODES + MODE_W'(1), '0, '0, '0, '0, '0, '0);
        send_word(CMD_QUERY, '1, '0);
        send_word(CMD_PLY, '0, '1);

        // Random phases, each opened once the block has drained
        for (int p = 0; sent < ITEM_TARGET; p++) begin
            calm = (p == 4);
            run_phase(p);
        end
        calm = 1'b0;

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
